// File: src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: src/bsa_pkg.sv
// Shared types and constants for the bitmap slab allocator.
// No dependencies.
package bsa_pkg;
    localparam int NumBufs = 16;
    localparam int MaxSegs = 256;
    localparam int WordsPerBuf = (MaxSegs + 63) / 64;
    localparam int WordAw = $clog2(NumBufs * WordsPerBuf);

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOID  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // bitmap memory access from the controller
    typedef struct packed {
        logic              rd_en;
        logic [WordAw-1:0] rd_addr;
        logic              wr_en;
        logic [WordAw-1:0] wr_addr;
        logic [63:0]       wr_data;
    } mem_req_t;
endpackage

// File: src/bitmap_slab_allocator.sv
// Bitmap slab allocator: one result item per input item, one item at a time.
// Clear, unknown kind and an alloc with no free id load the result from idle; alloc
// scans the current buffer in S_SCAN (one bitmap word per cycle), after S_OPEN when
// it opens a buffer (4 word writes, one scan); free goes through S_FRD and S_FCHK,
// ends in S_FRD when rejected. Next item is taken once idle and the result moves.
// Reset clears all control state; bitmap words and use counts are written on open.
`include "assert_macros.svh"
module bitmap_slab_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // kind[1:0], buf_id[5:2], offset[13:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[1:0], out_buf[5:2], out_offset[13:6],
                                   // buffer_opened[14], buffer_released[15],
                                   // total_in_use[28:16]
);
    localparam int NB = bsa_pkg::NumBufs;
    localparam int WA = bsa_pkg::WordAw;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_OPEN = 6'b000010,
        S_SCAN = 6'b000100,
        S_FRD  = 6'b001000,
        S_FCHK = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    logic [8:0]  spb_reg;
    logic [NB-1:0] live_reg, space_reg;
    logic [4:0]  live_cnt_reg;
    logic        cur_v_reg;
    logic [3:0]  cur_reg;
    logic [12:0] total_reg;
    logic [8:0]  use_cnt [NB];
    logic [3:0]  bid_reg;
    logic [7:0]  off_reg;
    logic [1:0]  widx_reg;
    logic        opened_reg;
    logic        mv_reg;
    logic [31:0] mdata_reg;

    bsa_pkg::mem_req_t req;
    logic [63:0] rd_data;

    bsa_bitmap_ram u_ram (.clk(clk), .req(req), .rd_data(rd_data));

    // effective segments per buffer, 1..256
    logic [8:0] spb;
    always_comb
    begin
        if (spb_reg == 9'd0) spb = 9'd1;
        else if (spb_reg > 9'd256) spb = 9'd256;
        else spb = spb_reg;
    end

    assign s_tready = (state_reg == S_IDLE) && (!mv_reg || m_tready);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    wire acc = s_tvalid && s_tready;

    // free-id search: downward from live count
    logic       id_ok;
    logic [3:0] id_sel;
    always_comb
    begin
        id_ok  = 1'b0;
        id_sel = 4'd0;
        for (int i = 0; i < NB; i++)
        begin
            if (i <= live_cnt_reg && !live_reg[i])
            begin
                id_ok  = 1'b1;
                id_sel = 4'(i);
            end
        end
        if (live_cnt_reg >= 5'(NB)) id_ok = 1'b0;
    end

    // lowest id in a set
    function automatic logic [4:0] low_set(input logic [NB-1:0] s);
        logic [4:0] r;
        r = 5'd0;
        for (int i = NB - 1; i >= 0; i--)
        begin
            if (s[i]) r = {1'b1, 4'(i)};
        end
        return r;
    endfunction

    // mask of bits below spb for one word index
    function automatic logic [63:0] word_mask(input logic [1:0] w, input logic [8:0] s);
        logic [63:0] m;
        logic [9:0]  base;
        base = {2'b00, w, 6'd0};
        for (int i = 0; i < 64; i++)
        begin
            m[i] = (base + 10'(i)) < {1'b0, s};
        end
        return m;
    endfunction

    logic [63:0] scan_w;
    logic        scan_hit;
    logic [5:0]  scan_pos;
    always_comb
    begin
        scan_w   = rd_data & word_mask(widx_reg, spb);
        scan_hit = 1'b0;
        scan_pos = 6'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (scan_w[i])
            begin
                scan_hit = 1'b1;
                scan_pos = 6'(i);
            end
        end
    end

    logic [7:0] seg_found;
    assign seg_found = {widx_reg, scan_pos};
    logic [WA-1:0] cur_word;
    assign cur_word = {cur_reg, widx_reg};
    logic [WA-1:0] fr_word;
    assign fr_word = {bid_reg, off_reg[7:6]};

    // response packing
    function automatic logic [31:0] pack(input logic [1:0] st, input logic [3:0] b,
                                         input logic [7:0] o, input logic op,
                                         input logic rl, input logic [12:0] t);
        return {3'd0, t, rl, op, o, b, st};
    endfunction

    logic [8:0] uc_dec;
    logic       bad;

    always_comb
    begin
        req        = '0;
        uc_dec     = use_cnt[bid_reg];
        bad        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && s_tdata[1:0] == bsa_pkg::KIND_ALLOC)
                begin
                    if (cur_v_reg)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = {cur_reg, 2'd0};
                    end
                end
                else if (acc && s_tdata[1:0] == bsa_pkg::KIND_FREE)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = {s_tdata[5:2], s_tdata[13:12]};
                end
            end
            S_OPEN:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = cur_word;
                req.wr_data = word_mask(widx_reg, spb);
                if (widx_reg == 2'd3)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = {cur_reg, 2'd0};
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = cur_word;
                    req.wr_data = rd_data & ~(64'd1 << scan_pos);
                end
                else if (widx_reg != 2'd3)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = {cur_reg, widx_reg + 2'd1};
                end
            end
            S_FRD:
            begin
                bad = !live_reg[bid_reg] || ({1'b0, off_reg} >= spb) || rd_data[off_reg[5:0]];
                if (!bad)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = fr_word;
                    req.wr_data = rd_data | (64'd1 << off_reg[5:0]);
                end
            end
            S_FCHK, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // cycles in which a result item is loaded into the output register
    logic out_load;
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  out_load = acc && (s_tdata[1:0] != bsa_pkg::KIND_FREE)
                                && !(s_tdata[1:0] == bsa_pkg::KIND_ALLOC
                                     && (cur_v_reg || id_ok));
            S_SCAN:  out_load = scan_hit || (widx_reg == 2'd3);
            S_FRD:   out_load = bad;
            S_FCHK:  out_load = 1'b1;
            default: out_load = 1'b0;
        endcase
    end

    // controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            spb_reg      <= 9'd256;
            live_reg     <= '0;
            space_reg    <= '0;
            live_cnt_reg <= '0;
            cur_v_reg    <= 1'b0;
            cur_reg      <= '0;
            total_reg    <= '0;
            mv_reg       <= 1'b0;
            widx_reg     <= '0;
            opened_reg   <= 1'b0;
        end
        else
        begin
            logic [4:0]    lo;
            logic [NB-1:0] sp;
            logic [8:0]    uc;
            logic [12:0]   t;
            if (cfg_we) spb_reg <= cfg_wdata;
            if (out_load) mv_reg <= 1'b1;
            else if (mv_reg && m_tready) mv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        bid_reg    <= s_tdata[5:2];
                        off_reg    <= s_tdata[13:6];
                        widx_reg   <= 2'd0;
                        opened_reg <= 1'b0;
                        if (s_tdata[1:0] == bsa_pkg::KIND_ALLOC)
                        begin
                            if (cur_v_reg)
                            begin
                                state_reg <= S_SCAN;
                            end
                            else if (!id_ok)
                            begin
                                mdata_reg <= pack(bsa_pkg::ST_NOID, 4'd0, 8'd0, 1'b0, 1'b0,
                                                  total_reg);
                            end
                            else
                            begin
                                live_reg[id_sel]  <= 1'b1;
                                space_reg[id_sel] <= 1'b1;
                                live_cnt_reg      <= live_cnt_reg + 5'd1;
                                cur_v_reg         <= 1'b1;
                                cur_reg           <= id_sel;
                                use_cnt[id_sel]   <= 9'd0;
                                opened_reg        <= 1'b1;
                                state_reg         <= S_OPEN;
                            end
                        end
                        else if (s_tdata[1:0] == bsa_pkg::KIND_FREE)
                        begin
                            state_reg <= S_FRD;
                        end
                        else
                        begin
                            if (s_tdata[1:0] == bsa_pkg::KIND_CLEAR)
                            begin
                                live_reg     <= '0;
                                space_reg    <= '0;
                                live_cnt_reg <= '0;
                                cur_v_reg    <= 1'b0;
                                cur_reg      <= '0;
                                total_reg    <= '0;
                                t = 13'd0;
                            end
                            else
                            begin
                                t = total_reg;
                            end
                            mdata_reg <= pack(bsa_pkg::ST_OK, 4'd0, 8'd0, 1'b0, 1'b0, t);
                        end
                    end
                end
                S_OPEN:
                begin
                    widx_reg <= widx_reg + 2'd1;
                    if (widx_reg == 2'd3) state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        uc = use_cnt[cur_reg] + 9'd1;
                        use_cnt[cur_reg] <= uc;
                        total_reg <= total_reg + 13'd1;
                        if (uc >= spb)
                        begin
                            sp = space_reg;
                            sp[cur_reg] = 1'b0;
                            space_reg <= sp;
                            lo = low_set(sp);
                            cur_v_reg <= lo[4];
                            cur_reg   <= lo[3:0];
                        end
                        mdata_reg <= pack(bsa_pkg::ST_OK, cur_reg, seg_found, opened_reg,
                                          1'b0, total_reg + 13'd1);
                        state_reg <= S_IDLE;
                    end
                    else if (widx_reg == 2'd3)
                    begin
                        sp = space_reg;
                        sp[cur_reg] = 1'b0;
                        space_reg <= sp;
                        lo = low_set(sp);
                        cur_v_reg <= lo[4];
                        cur_reg   <= lo[3:0];
                        mdata_reg <= pack(bsa_pkg::ST_NOID, 4'd0, 8'd0, opened_reg, 1'b0,
                                          total_reg);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        widx_reg <= widx_reg + 2'd1;
                    end
                end
                S_FRD:
                begin
                    if (bad)
                    begin
                        mdata_reg <= pack(bsa_pkg::ST_BAD, 4'd0, 8'd0, 1'b0, 1'b0, total_reg);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (total_reg != 13'd0) total_reg <= total_reg - 13'd1;
                        uc = uc_dec;
                        if (uc != 9'd0) uc = uc - 9'd1;
                        use_cnt[bid_reg] <= uc;
                        space_reg[bid_reg] <= 1'b1;
                        state_reg <= S_FCHK;
                    end
                end
                S_FCHK:
                begin
                    t = total_reg;
                    if (use_cnt[bid_reg] != 9'd0 || space_reg == (NB'(1) << bid_reg))
                    begin
                        if (!cur_v_reg)
                        begin
                            cur_v_reg <= 1'b1;
                            cur_reg   <= bid_reg;
                        end
                        mdata_reg <= pack(bsa_pkg::ST_OK, 4'd0, 8'd0, 1'b0, 1'b0, t);
                    end
                    else
                    begin
                        sp = space_reg;
                        sp[bid_reg] = 1'b0;
                        space_reg <= sp;
                        live_reg[bid_reg] <= 1'b0;
                        if (live_cnt_reg != 5'd0) live_cnt_reg <= live_cnt_reg - 5'd1;
                        if (cur_v_reg && cur_reg == bid_reg)
                        begin
                            lo = low_set(sp);
                            cur_v_reg <= lo[4];
                            cur_reg   <= lo[3:0];
                        end
                        mdata_reg <= pack(bsa_pkg::ST_OK, 4'd0, 8'd0, 1'b0, 1'b1, t);
                    end
                    state_reg <= S_IDLE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_onehot, clk, rst_n, $onehot(state_reg))
    `ASSERT_CLK(a_cur_live, clk, rst_n, cur_v_reg |-> live_reg[cur_reg])
    `ASSERT_CLK(a_space_live, clk, rst_n, (space_reg & ~live_reg) == '0)
    `ASSERT_CLK(a_cnt, clk, rst_n, live_cnt_reg == 5'($countones(live_reg)))
endmodule

// File: src/bsa_bitmap_ram.sv
// Free-bitmap word memory: one write and one registered read port.
// Depends on bsa_pkg.
module bsa_bitmap_ram (
    input  logic              clk,
    input  bsa_pkg::mem_req_t req,
    output logic [63:0]       rd_data
);
    localparam int NumWords = bsa_pkg::NumBufs * bsa_pkg::WordsPerBuf;
    logic [63:0] mem [NumWords];

    // write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule

// File: tb/alloc_checker.sv
// Checker for the slab allocator: watches the config, input and result channels,
// predicts each result from its own model of the allocator, and counts mismatches.
// Depends on bsa_pkg for kind and status codes.
module alloc_checker
    import bsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [12:0] total;
        logic        released;
        logic        opened;
        logic [7:0]  offset;
        logic [3:0]  buf_id;
        logic [1:0]  status;
    } alloc_result_t;

    // allocator model state
    logic [MaxSegs-1:0] seg_free [NumBufs];
    logic [NumBufs-1:0] live;
    logic [NumBufs-1:0] space;
    int                 live_cnt;
    int                 uses [NumBufs];
    logic               cur_valid;
    logic [3:0]         cur_buf;
    int                 total;
    int                 seg_limit;

    alloc_result_t      expected_results [$];

    assign pending = expected_results.size();

    // current buffer moves to the lowest id that still has space
    function automatic void pick_current();
        cur_valid = 1'b0;
        cur_buf   = '0;
        for (int i = NumBufs - 1; i >= 0; i--)
        begin
            if (space[i])
            begin
                cur_valid = 1'b1;
                cur_buf   = i[3:0];
            end
        end
    endfunction

    function automatic alloc_result_t allocate();
        alloc_result_t r;
        int            id;
        int            seg;
        r = '0;
        if (!cur_valid)
        begin
            id = live_cnt;
            if (id >= NumBufs)
            begin
                r.status = ST_NOID;
                return r;
            end
            while (live[id] && id > 0)
                id--;
            if (live[id])
            begin
                r.status = ST_NOID;
                return r;
            end
            live[id]  = 1'b1;
            live_cnt++;
            space[id] = 1'b1;
            cur_valid = 1'b1;
            cur_buf   = id[3:0];
            uses[id]  = 0;
            for (int i = 0; i < MaxSegs; i++)
                seg_free[id][i] = (i < seg_limit);
            r.opened = 1'b1;
        end
        id  = cur_buf;
        seg = -1;
        for (int i = seg_limit - 1; i >= 0; i--)
            if (seg_free[id][i])
                seg = i;
        // register shrunk under a live buffer: nothing free below the limit
        if (seg < 0)
        begin
            space[id] = 1'b0;
            pick_current();
            r.status = ST_NOID;
            return r;
        end
        seg_free[id][seg] = 1'b0;
        total++;
        uses[id]++;
        if (uses[id] >= seg_limit)
        begin
            space[id] = 1'b0;
            pick_current();
        end
        r.status = ST_OK;
        r.buf_id = id[3:0];
        r.offset = seg[7:0];
        return r;
    endfunction

    function automatic alloc_result_t release_segment(int id, int seg);
        alloc_result_t r;
        r = '0;
        if (!live[id] || seg >= seg_limit || seg_free[id][seg])
        begin
            r.status = ST_BAD;
            return r;
        end
        seg_free[id][seg] = 1'b1;
        if (total > 0)
            total--;
        if (uses[id] > 0)
            uses[id]--;
        space[id] = 1'b1;
        // keep a buffer that is still in use, or the only one with space
        if (uses[id] != 0 || $countones(space) == 1)
        begin
            if (!cur_valid)
            begin
                cur_valid = 1'b1;
                cur_buf   = id[3:0];
            end
            return r;
        end
        space[id] = 1'b0;
        live[id]  = 1'b0;
        if (live_cnt > 0)
            live_cnt--;
        if (cur_valid && cur_buf == id)
            pick_current();
        r.released = 1'b1;
        return r;
    endfunction

    function automatic alloc_result_t predict_result(logic [15:0] d);
        alloc_result_t r;
        r = '0;
        case (d[1:0])
            KIND_ALLOC: r = allocate();
            KIND_FREE:  r = release_segment(d[5:2], d[13:6]);
            KIND_CLEAR:
            begin
                live      = '0;
                space     = '0;
                live_cnt  = 0;
                cur_valid = 1'b0;
                cur_buf   = '0;
                total     = 0;
            end
            default: ;
        endcase
        r.total = total[12:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t got;
        alloc_result_t want;
        if (!rst_n)
        begin
            live      = '0;
            space     = '0;
            live_cnt  = 0;
            cur_valid = 1'b0;
            cur_buf   = '0;
            total     = 0;
            seg_limit = MaxSegs;
            errors    = 0;
            for (int i = 0; i < NumBufs; i++)
            begin
                uses[i]     = 0;
                seg_free[i] = '0;
            end
            expected_results.delete();
        end
        else
        begin
            // segment limit saturates to 1..MaxSegs
            if (cfg_we)
                seg_limit = (cfg_wdata == 0) ? 1 : (cfg_wdata > MaxSegs) ? MaxSegs : cfg_wdata;
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(), predict_result(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[28:0];
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result item %h", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.buf_id != want.buf_id
                        || got.offset != want.offset || got.opened != want.opened
                        || got.released != want.released || got.total != want.total)
                    begin
                        errors++;
                        $display("%0t: expected st=%0d buf=%0d off=%0d open=%0b rel=%0b tot=%0d",
                                 $time, want.status, want.buf_id, want.offset, want.opened,
                                 want.released, want.total);
                        $display("%0t:   actual st=%0d buf=%0d off=%0d open=%0b rel=%0b tot=%0d",
                                 $time, got.status, got.buf_id, got.offset, got.opened,
                                 got.released, got.total);
                    end
                end
            end
        end
    end
endmodule

// File: tb/tb.sv
// Testbench top for the slab allocator: drives config and request items with
// random gaps and result stalls, and gives the verdict from alloc_checker.
// Depends on bsa_pkg, bitmap_slab_allocator and alloc_checker.
module tb;
    import bsa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          errors;
    int          pending;
    int          cycles;
    bit          no_gaps;

    // segments handed out, used to build legal frees
    logic [11:0] held_segments [$];
    // kinds of accepted items, in order, to tell alloc results apart
    logic [1:0]  sent_kinds [$];

    bitmap_slab_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    alloc_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: per-item stall, then hold ready until the item moves
    always @(posedge clk)
    begin
        int         stall;
        logic [1:0] res_kind;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                res_kind = sent_kinds.pop_front();
                if (res_kind == KIND_ALLOC && m_tdata[1:0] == ST_OK
                    && held_segments.size() < 4096)
                    held_segments.insert(held_segments.size(), m_tdata[13:2]);
                stall = no_gaps ? 0 : $urandom_range(15);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_item(logic [1:0] kind, logic [3:0] id, logic [7:0] off);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, off, id, kind};
        do
            @(posedge clk);
        while (!s_tready);
        sent_kinds.insert(sent_kinds.size(), kind);
    endtask

    // frees are only legal for the pool gathered from alloc results
    task automatic send_held_free();
        int          k;
        logic [11:0] seg;
        k   = $urandom_range(held_segments.size() - 1);
        seg = held_segments[k];
        held_segments.delete(k);
        send_item(KIND_FREE, seg[3:0], seg[11:4]);
    endtask

    task automatic drain_and_configure(logic [8:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [8:0] limits [8];
        int         pick;
        limits = '{9'd256, 9'd1, 9'd0, 9'd3, 9'd511, 9'd2, 9'd300, 9'd5};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b1;
        cycles    = 0;
        no_gaps   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: opens, bad frees, unknown kind, clear
        send_item(KIND_FREE, 4'd15, 8'd255);
        send_item(KIND_ALLOC, 4'd0, 8'd0);
        send_item(KIND_ALLOC, 4'd0, 8'd0);
        send_item(KIND_FREE, 4'd0, 8'd1);
        send_item(KIND_FREE, 4'd0, 8'd1);
        send_item(KIND_FREE, 4'd0, 8'd255);
        send_item(2'd3, 4'd15, 8'd255);
        send_item(KIND_FREE, 4'd0, 8'd0);
        send_item(KIND_ALLOC, 4'd0, 8'd0);
        send_item(KIND_CLEAR, 4'd10, 8'd170);
        send_item(KIND_FREE, 4'd0, 8'd0);
        drain_and_configure(9'd1);
        held_segments.delete();
        // one segment per buffer: fill all 16 buffers, then run out of ids
        repeat (17) send_item(KIND_ALLOC, 4'd5, 8'd85);
        send_item(KIND_FREE, 4'd15, 8'd0);
        send_item(KIND_FREE, 4'd3, 8'd0);
        send_item(KIND_ALLOC, 4'd0, 8'd0);
        drain_and_configure(9'd256);
        // register grown under live buffers
        send_item(KIND_ALLOC, 4'd0, 8'd0);

        // random phases over several limits
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_and_configure(phase == 7 ? 9'($urandom_range(511)) : limits[phase]);
            for (int n = 0; n < 94; n++)
            begin
                if (n % 32 == 0)
                    no_gaps = ($urandom_range(3) == 0);
                pick = $urandom_range(99);
                if (pick < 55)
                    send_item(KIND_ALLOC, 4'($urandom), 8'($urandom));
                else if (pick < 85 && held_segments.size() > 0)
                    send_held_free();
                else if (pick < 95)
                    send_item(KIND_FREE, 4'($urandom), 8'($urandom_range(pick & 1 ? 255 : 7)));
                else if (pick < 98)
                    send_item(2'd3, 4'($urandom), 8'($urandom));
                else
                begin
                    send_item(KIND_CLEAR, 4'($urandom), 8'($urandom));
                    held_segments.delete();
                end
            end
        end
        s_tvalid <= 1'b0;
        no_gaps  = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
